@@ src/vhsg_pkg.sv @@
// ----------------------------------------------------------------------------
// vhsg_pkg
// Shared constants, types and lookup tables for the VL-SNR header generator.
// ----------------------------------------------------------------------------
package vhsg_pkg;

    localparam int HDR_LEN     = 900;
    localparam int PAD_LEAD    = 2;
    localparam int PATTERN_LEN = 896;
    localparam int ROW_BITS    = 56;

    localparam int POS_W = 10;
    localparam int ROW_W = 4;
    localparam int COL_W = 6;
    localparam int MC_W  = 4;

    localparam logic [POS_W-1:0] POS_LAST     = POS_W'(HDR_LEN - 1);
    localparam logic [POS_W-1:0] POS_PAT_FIRST = POS_W'(PAD_LEAD);
    localparam logic [POS_W-1:0] POS_PAT_LAST  = POS_W'(PAD_LEAD + PATTERN_LEN - 1);
    localparam logic [COL_W-1:0] COL_LAST     = COL_W'(ROW_BITS - 1);
    localparam logic [MC_W-1:0]  MODCOD_RESET = MC_W'(1);

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    // one symbol position with its place in the base matrix
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } sym_pos_t;

    // base matrix row, first transmitted bit in bit 55
    function automatic logic [ROW_BITS-1:0] base_row(input logic [ROW_W-1:0] r);
        logic [ROW_BITS-1:0] v;
        unique case (r)
            4'd0:    v = 56'hFBF23E837F9BC4;
            4'd1:    v = 56'h98708E0B39345E;
            4'd2:    v = 56'hF6A2C9FE1B1737;
            4'd3:    v = 56'h8418D95A6F997A;
            4'd4:    v = 56'h7B7D7B3E9FC9EA;
            4'd5:    v = 56'h5E78BA03A6D51A;
            4'd6:    v = 56'h279CC26543ECD0;
            4'd7:    v = 56'h342B0498BF3D7D;
            4'd8:    v = 56'hADD036E9D5312F;
            4'd9:    v = 56'h1061C6DF826237;
            4'd10:   v = 56'h72D3E0907384C7;
            4'd11:   v = 56'h3BD5ACEE25E2C9;
            4'd12:   v = 56'h59087D82615ADA;
            4'd13:   v = 56'hE9AF0172CF9DA7;
            4'd14:   v = 56'h3F4835A4063F07;
            4'd15:   v = 56'h23C9AEECF2ED41;
            default: v = '0;
        endcase
        return v;
    endfunction

    // walsh-hadamard row inversion mask, bit r set when row r is inverted
    function automatic logic [15:0] invert_mask(input logic [MC_W-1:0] mc);
        logic [15:0] m;
        unique case (mc)
            4'd1:    m = 16'h0000;
            4'd2:    m = 16'hAAAA;
            4'd3:    m = 16'hCCCC;
            4'd4:    m = 16'h6666;
            4'd5:    m = 16'hF0F0;
            4'd6:    m = 16'h9696;
            4'd7:    m = 16'h3C3C;
            4'd8:    m = 16'h5A5A;
            4'd9:    m = 16'h00FF;
            default: m = 16'h0000;
        endcase
        return m;
    endfunction

endpackage

@@ src/vhsg_sequencer.sv @@
// ----------------------------------------------------------------------------
// vhsg_sequencer
// Input stage: tracks the header position and registers it per accepted item.
// ----------------------------------------------------------------------------
module vhsg_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                restart,
    output logic                sym_valid,
    input  logic                sym_ready,
    output vhsg_pkg::sym_pos_t  sym
);
    import vhsg_pkg::*;

    sym_pos_t cur;
    sym_pos_t cnt_reg, cnt_next;
    sym_pos_t sym_reg;
    logic     valid_reg, valid_next;
    logic     accept;

    assign in_ready = !valid_reg || sym_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cur = restart ? sym_pos_t'('0) : cnt_reg;

        cnt_next.pos = (cur.pos == POS_LAST) ? '0 : cur.pos + POS_W'(1);
        // row and column advance only inside the pattern part
        if (cur.pos >= POS_PAT_FIRST && cur.pos <= POS_PAT_LAST)
        begin
            if (cur.col == COL_LAST)
            begin
                cnt_next.col = '0;
                cnt_next.row = cur.row + ROW_W'(1);
            end
            else
            begin
                cnt_next.col = cur.col + COL_W'(1);
                cnt_next.row = cur.row;
            end
        end
        else
        begin
            cnt_next.col = '0;
            cnt_next.row = '0;
        end

        valid_next = accept ? 1'b1 : (sym_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (accept)
                cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            sym_reg <= cur;
    end

    assign sym_valid = valid_reg;
    assign sym       = sym_reg;

endmodule

@@ src/vhsg_mapper.sv @@
// ----------------------------------------------------------------------------
// vhsg_mapper
// Chip lookup, sign-row inversion and pi/2-BPSK sign mapping into the result
// register.
// ----------------------------------------------------------------------------
module vhsg_mapper (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sym_valid,
    output logic                           sym_ready,
    input  vhsg_pkg::sym_pos_t             sym,
    input  logic [vhsg_pkg::MC_W-1:0]      modcod,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           i_negative,
    output logic                           q_negative,
    output logic [vhsg_pkg::POS_W-1:0]     symbol_index,
    output logic                           last
);
    import vhsg_pkg::*;

    logic [ROW_BITS-1:0] row_bits;
    logic [15:0]         mask;
    logic                pad;
    logic                chip_neg;
    logic                load;

    logic                valid_reg, valid_next;
    logic                i_neg_reg, q_neg_reg, last_reg;
    logic [POS_W-1:0]    index_reg;

    always_comb
    begin
        row_bits = base_row(sym.row);
        mask     = invert_mask(modcod);
        pad      = (sym.pos < POS_PAT_FIRST) || (sym.pos > POS_PAT_LAST);
        chip_neg = pad ? 1'b0 : (row_bits[COL_LAST - sym.col] ^ mask[sym.row]);
    end

    assign sym_ready  = !valid_reg || out_ready;
    assign load       = sym_valid && sym_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            i_neg_reg <= chip_neg ^ sym.pos[0];
            q_neg_reg <= chip_neg;
            index_reg <= sym.pos;
            last_reg  <= (sym.pos == POS_LAST);
        end
    end

    assign out_valid    = valid_reg;
    assign i_negative   = i_neg_reg;
    assign q_negative   = q_neg_reg;
    assign symbol_index = index_reg;
    assign last         = last_reg;

endmodule

@@ src/vlsnr_header_symbol_generator.sv @@
// ----------------------------------------------------------------------------
// vlsnr_header_symbol_generator
// DVB-S2X VL-SNR header symbol source, one pi/2-BPSK sign pair per item.
// ----------------------------------------------------------------------------
// Each accepted input item yields one header symbol; a full header is 900
// items and the next header follows without a restart. Throughput is one
// item per clock; each item passes the position register, then the result
// register; both stages hold under back-pressure, so while a result waits
// the input takes one more item into the position register and then stalls
// until the result is taken. The base matrix and sign rows are constant
// tables read in the mapping stage. modcod is written through the cfg port
// (reset value 1) and must only change while the stream is idle; codes
// outside 1..9 give the uninverted pattern.
module vlsnr_header_symbol_generator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [vhsg_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // [0] restart, [7:1] zero
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [vhsg_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // [0] i_negative,
                                                                 // [1] q_negative,
                                                                 // [11:2] symbol_index,
                                                                 // [15:12] zero
    output logic                                  m_axis_tlast,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [vhsg_pkg::MC_W-1:0]             cfg_data
);
    import vhsg_pkg::*;

    logic [MC_W-1:0]  modcod_reg;
    logic             sym_valid, sym_ready;
    sym_pos_t         sym;
    logic             i_neg, q_neg;
    logic [POS_W-1:0] index;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modcod_reg <= MODCOD_RESET;
        else if (cfg_valid && cfg_ready)
            modcod_reg <= cfg_data;
    end

    vhsg_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .restart   (s_axis_tdata[0]),
        .sym_valid (sym_valid),
        .sym_ready (sym_ready),
        .sym       (sym)
    );

    vhsg_mapper u_map (
        .clk          (clk),
        .rst_n        (rst_n),
        .sym_valid    (sym_valid),
        .sym_ready    (sym_ready),
        .sym          (sym),
        .modcod       (modcod_reg),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .i_negative   (i_neg),
        .q_negative   (q_neg),
        .symbol_index (index),
        .last         (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, index, q_neg, i_neg};

endmodule

@@ src/vhsg_checker.sv @@
// ----------------------------------------------------------------------------
// vhsg_checker
// Port-level checks on the header symbol stream, bound to the top level.
// ----------------------------------------------------------------------------
module vhsg_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic [vhsg_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    input  logic                                  m_axis_tlast
);
    import vhsg_pkg::*;

    logic [POS_W-1:0] idx;
    assign idx = m_axis_tdata[11:2];

    // tlast marks exactly the final header symbol
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (idx == POS_LAST)))
        else $error("tlast does not match symbol index");

    // pad positions carry chip +1
    a_pad_chip: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (idx < POS_PAT_FIRST || idx > POS_PAT_LAST))
        |-> (m_axis_tdata[1] == 1'b0 && m_axis_tdata[0] == idx[0]))
        else $error("pad symbol has wrong sign");

    // index in range and unused bits zero
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (idx <= POS_LAST && m_axis_tdata[15:12] == 4'b0000))
        else $error("symbol index out of range or fill bits set");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("output changed while stalled");

endmodule

bind vlsnr_header_symbol_generator vhsg_checker u_vhsg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream testbench for the VL-SNR header symbol generator. A scoreboard
// predicts each header symbol from the restart flag and the current modcod,
// then checks every output item against it in order. The run covers restarts,
// header wrap, directed and random modcods including out-of-range codes, bursty input and
// stalled output.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1400;
    localparam int HOLD_CYCLES  = 80;
    localparam int LATENCY      = 4;

    // base matrix, row 0 first, most significant bit transmitted first
    localparam logic [16*56-1:0] BASE_MATRIX = {
        56'hFBF23E837F9BC4, 56'h98708E0B39345E, 56'hF6A2C9FE1B1737, 56'h8418D95A6F997A,
        56'h7B7D7B3E9FC9EA, 56'h5E78BA03A6D51A, 56'h279CC26543ECD0, 56'h342B0498BF3D7D,
        56'hADD036E9D5312F, 56'h1061C6DF826237, 56'h72D3E0907384C7, 56'h3BD5ACEE25E2C9,
        56'h59087D82615ADA, 56'hE9AF0172CF9DA7, 56'h3F4835A4063F07, 56'h23C9AEECF2ED41
    };

    // row inversion masks, modcod m in bits [16*(m-1) +: 16]
    localparam logic [9*16-1:0] SIGN_ROWS = {
        16'h00FF, 16'h5A5A, 16'h3C3C, 16'h9696, 16'hF0F0,
        16'h6666, 16'hCCCC, 16'hAAAA, 16'h0000
    };

    typedef struct packed {
        logic       i_negative;
        logic       q_negative;
        logic [9:0] symbol_index;
        logic       last;
    } header_symbol_t;

    class header_scoreboard;
        logic [3:0]     modcod = 4'd1;
        logic [9:0]     next_pos = '0;
        header_symbol_t symbol_q[$];
        int             mismatches = 0;
        int             headers_done = 0;

        function int pending();
            return symbol_q.size();
        endfunction

        function void note_input(logic restart);
            header_symbol_t s;
            logic [15:0]    mask;
            logic [9:0]     p;
            logic           chip;
            int             k;
            if (restart)
                next_pos = '0;
            p = next_pos;
            chip = 1'b0;
            if (p >= 10'd2 && p <= 10'd897)
            begin
                k = int'(p) - 2;
                mask = (modcod >= 4'd1 && modcod <= 4'd9) ?
                       SIGN_ROWS[16*(int'(modcod)-1) +: 16] : 16'h0000;
                chip = BASE_MATRIX[895-k] ^ mask[k/56];
            end
            s.i_negative   = chip ^ p[0];
            s.q_negative   = chip;
            s.symbol_index = p;
            s.last         = (p == 10'd899);
            symbol_q.push_back(s);
            if (s.last)
                headers_done++;
            next_pos = s.last ? 10'd0 : p + 10'd1;
        endfunction

        function void compare_field(string name, int want, int got, int idx);
            if (want != got)
            begin
                mismatches++;
                $display("%0t: symbol %0d %s expected %0d actual %0d",
                         $time, idx, name, want, got);
            end
        endfunction

        function void check_symbol(logic [15:0] tdata, logic tlast);
            header_symbol_t e;
            if (symbol_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected item, expected none actual tdata %h tlast %b",
                         $time, tdata, tlast);
                return;
            end
            e = symbol_q.pop_front();
            compare_field("i_negative", e.i_negative, tdata[0], e.symbol_index);
            compare_field("q_negative", e.q_negative, tdata[1], e.symbol_index);
            compare_field("symbol_index", e.symbol_index, tdata[11:2], e.symbol_index);
            compare_field("last", e.last, tlast, e.symbol_index);
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [vhsg_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;   // [0] restart
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [vhsg_pkg::OUT_TDATA_W-1:0] m_axis_tdata;       // [0] i_negative, [1] q_negative,
                                                          // [11:2] symbol_index
    logic                            m_axis_tlast;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [vhsg_pkg::MC_W-1:0]       cfg_data = '0;

    header_scoreboard sb = new();
    bit               hold_off_req = 1'b0;
    int               cycle_count = 0;

    vlsnr_header_symbol_generator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_symbol(m_axis_tdata, m_axis_tlast);
    end

    // output stall pattern in randomly chosen styles
    initial
    begin
        int         stall_mode;
        int         mode_left;
        logic [7:0] stall_pattern;
        stall_mode = 0;
        mode_left = 0;
        stall_pattern = 8'hFF;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_pattern = 8'($urandom_range(0, 255));
                mode_left = 150;
            end
            mode_left--;
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:
                begin
                    m_axis_tready <= stall_pattern[0];
                    stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
                end
                default: m_axis_tready <= ($urandom_range(0, 5) != 0);
            endcase
        end
    end

    task automatic offer_symbol(logic restart);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'b0, restart};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_input(restart);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_modcod(logic [3:0] mc);
        wait_drained();
        repeat (LATENCY) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= mc;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.modcod = mc;
    endtask

    task automatic directed_run(logic [3:0] mc, logic [7:0] restarts, int count);
        write_modcod(mc);
        for (int i = 0; i < count; i++)
            offer_symbol(restarts[i]);
        s_axis_tvalid <= 1'b0;
    endtask

    // bursty sender, gaps off with no_gaps; restarts only once a full header has been sent
    task automatic send_symbols(int count, bit no_gaps);
        int   burst_left;
        int   gap;
        logic restart;
        burst_left = 0;
        for (int n = 0; n < count; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap != 0 && !no_gaps)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            restart = (sb.headers_done > 0) && ($urandom_range(0, 79) == 0);
            offer_symbol(restart);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial
    begin
        int         sent;
        int         phase;
        int         len;
        logic [3:0] mc;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset modcod: restart at position zero, pads into pattern, restart mid-header
        offer_symbol(1'b1);
        repeat (4) offer_symbol(1'b0);
        offer_symbol(1'b1);
        offer_symbol(1'b0);
        s_axis_tvalid <= 1'b0;
        directed_run(4'd9, 8'b0000_0001, 4);
        directed_run(4'd0, 8'b0000_0010, 3);
        directed_run(4'd15, 8'b0000_0000, 3);

        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case (phase)
                0:       mc = 4'd9;
                1:       mc = 4'd0;
                2:       mc = 4'd15;
                default: mc = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                                          : 4'($urandom_range(1, 9));
            endcase
            write_modcod(mc);
            len = $urandom_range(60, 200);
            if (phase == 3)
            begin
                // long output hold-off while input keeps coming
                hold_off_req = 1'b1;
                send_symbols(len, 1'b1);
            end
            else
                send_symbols(len, 1'b0);
            sent += len;
            phase++;
        end

        wait_drained();
        repeat (LATENCY) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
src/vhsg_pkg.sv
src/vhsg_sequencer.sv
src/vhsg_mapper.sv
src/vlsnr_header_symbol_generator.sv
src/vhsg_checker.sv
sim/tb.sv
